@@ rtl/core/fsfp_pkg.sv @@
// Package for the format specification flag parser.
// Holds character codes, the parse phase type, length codes and the result record.
// No dependencies.
package fsfp_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int OUT_CNT_BITS = 16;
	localparam int STAR_BITS = 32;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_H = 8'h68;
	localparam logic [7:0] CH_L = 8'h6C;
	localparam logic [7:0] CH_BIG_L = 8'h4C;

	localparam int FLAG_BITS = 5;
	localparam logic [FLAG_BITS-1:0] F_MINUS = 5'b00001;
	localparam logic [FLAG_BITS-1:0] F_PLUS = 5'b00010;
	localparam logic [FLAG_BITS-1:0] F_SPACE = 5'b00100;
	localparam logic [FLAG_BITS-1:0] F_ZERO = 5'b01000;
	localparam logic [FLAG_BITS-1:0] F_HASH = 5'b10000;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_HH = 3'd1;
	localparam logic [2:0] LEN_H = 3'd2;
	localparam logic [2:0] LEN_LL = 3'd3;
	localparam logic [2:0] LEN_L = 3'd4;
	localparam logic [2:0] LEN_BIG_L = 3'd5;

	typedef enum logic [5:0] {
		PH_FLAGS = 6'b000001,
		PH_WIDTH = 6'b000010,
		PH_DOT   = 6'b000100,
		PH_PREC  = 6'b001000,
		PH_LEN1  = 6'b010000,
		PH_LEN2  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic                    left_justify;
		logic                    plus_sign;
		logic                    space_sign;
		logic                    zero_pad;
		logic                    alt_form;
		logic [OUT_CNT_BITS-1:0] field_width;
		logic                    prec_given;
		logic [OUT_CNT_BITS-1:0] prec_value;
		logic [2:0]              length_mod;
		logic [7:0]              conversion;
	} rec_t;

	function automatic logic [FLAG_BITS-1:0] flag_of(input logic [7:0] c);
		logic [FLAG_BITS-1:0] f;
		case (c)
			CH_MINUS: f = F_MINUS;
			CH_PLUS:  f = F_PLUS;
			CH_SPACE: f = F_SPACE;
			CH_ZERO:  f = F_ZERO;
			CH_HASH:  f = F_HASH;
			default:  f = '0;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/core/fsfp_in_stage.sv @@
// Input register of the format specification flag parser.
// Captures one word and precomputes the saturated star magnitude; uses fsfp_pkg.
module fsfp_in_stage #(
	parameter int COUNT_BITS = fsfp_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      ch,
	input  logic signed [fsfp_pkg::STAR_BITS-1:0] star_arg,
	input  logic                            advance,
	output logic                            valid_s1,
	output logic [7:0]                      ch_s1,
	output logic                            star_neg_s1,
	output logic [COUNT_BITS-1:0]           star_sat_s1
);
	import fsfp_pkg::*;

	logic                 star_neg;
	logic [STAR_BITS-1:0] star_mag;
	logic [COUNT_BITS-1:0] star_sat;
	logic                 take;

	assign star_neg = star_arg[STAR_BITS-1];
	assign star_mag = star_neg ? (~star_arg + STAR_BITS'(1)) : star_arg;
	assign star_sat = (|star_mag[STAR_BITS-1:COUNT_BITS]) ? '1 : star_mag[COUNT_BITS-1:0];

	assign in_stall = valid_s1 && !advance;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1 <= ch;
			star_neg_s1 <= star_neg;
			star_sat_s1 <= star_sat;
		end
	end

endmodule

@@ rtl/core/fsfp_parse_core.sv @@
// Parse state and per-character update of the format specification flag parser.
// Holds phase, flags, width, precision and length code; uses fsfp_pkg.
module fsfp_parse_core #(
	parameter int COUNT_BITS = fsfp_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            ch_s1,
	input  logic                  star_neg_s1,
	input  logic [COUNT_BITS-1:0] star_sat_s1,
	output logic                  emit,
	output fsfp_pkg::rec_t        rec
);
	import fsfp_pkg::*;

	phase_t                phase_q, phase_d;
	logic [FLAG_BITS-1:0]  flags_q, flags_d;
	logic [COUNT_BITS-1:0] width_q, width_d;
	logic [COUNT_BITS-1:0] prec_q, prec_d;
	logic                  seen_q, seen_d;
	logic [2:0]            len_q, len_d;

	logic                  digit;
	logic [3:0]            dval;
	logic                  is_w, is_dot, is_prec;
	logic [FLAG_BITS-1:0]  fl;
	logic [COUNT_BITS-1:0] width_step, prec_step;
	logic [COUNT_BITS+3:0] wext, pext, wprod, pprod, dext;
	logic [31:0]           width_wide, prec_wide;

	assign digit = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign dval = ch_s1[3:0];
	assign is_w = phase_q == PH_WIDTH;
	assign is_dot = phase_q == PH_DOT;
	assign is_prec = phase_q == PH_PREC;
	assign fl = flag_of(ch_s1);

	assign wext = {4'b0, width_q};
	assign pext = {4'b0, prec_q};
	assign dext = {{COUNT_BITS{1'b0}}, dval};
	assign wprod = (wext << 3) + (wext << 1) + dext;
	assign pprod = (pext << 3) + (pext << 1) + dext;
	assign width_step = (|wprod[COUNT_BITS+3:COUNT_BITS]) ? '1 : wprod[COUNT_BITS-1:0];
	assign prec_step = (|pprod[COUNT_BITS+3:COUNT_BITS]) ? '1 : pprod[COUNT_BITS-1:0];

	always_comb begin
		phase_d = phase_q;
		flags_d = flags_q;
		width_d = width_q;
		prec_d = prec_q;
		seen_d = seen_q;
		len_d = len_q;
		emit = 1'b0;
		unique case (phase_q)
			PH_LEN1: begin
				if (ch_s1 == CH_H && len_q == LEN_H) begin
					len_d = LEN_HH;
					phase_d = PH_LEN2;
				end else if (ch_s1 == CH_L && len_q == LEN_L) begin
					len_d = LEN_LL;
					phase_d = PH_LEN2;
				end else begin
					emit = 1'b1;
				end
			end
			PH_LEN2: begin
				emit = 1'b1;
			end
			default: begin
				if (digit && (is_w || is_dot || is_prec)) begin
					if (is_w) begin
						width_d = width_step;
					end else begin
						prec_d = prec_step;
						phase_d = PH_PREC;
					end
				end else if (digit && ch_s1 != CH_ZERO) begin
					width_d = COUNT_BITS'(dval);
					phase_d = PH_WIDTH;
				end else if (fl != '0) begin
					flags_d = flags_q | fl;
					phase_d = PH_FLAGS;
				end else if (ch_s1 == CH_STAR) begin
					if (is_dot) begin
						seen_d = !star_neg_s1;
						prec_d = star_neg_s1 ? '0 : star_sat_s1;
					end else begin
						if (star_neg_s1) begin
							flags_d = flags_q | F_MINUS;
						end
						width_d = star_sat_s1;
					end
					phase_d = PH_FLAGS;
				end else if (ch_s1 == CH_DOT) begin
					seen_d = 1'b1;
					prec_d = '0;
					phase_d = PH_DOT;
				end else if (ch_s1 == CH_H) begin
					len_d = LEN_H;
					phase_d = PH_LEN1;
				end else if (ch_s1 == CH_L) begin
					len_d = LEN_L;
					phase_d = PH_LEN1;
				end else if (ch_s1 == CH_BIG_L) begin
					len_d = LEN_BIG_L;
					phase_d = PH_LEN2;
				end else begin
					emit = 1'b1;
				end
			end
		endcase
		if (emit) begin
			phase_d = PH_FLAGS;
			flags_d = '0;
			width_d = '0;
			prec_d = '0;
			seen_d = 1'b0;
			len_d = LEN_NONE;
		end
	end

	assign width_wide = 32'(width_q);
	assign prec_wide = 32'(prec_q);

	always_comb begin
		rec.left_justify = flags_q[0];
		rec.plus_sign = flags_q[1];
		rec.space_sign = flags_q[2] && !flags_q[1];
		rec.zero_pad = flags_q[3] && !flags_q[0];
		rec.alt_form = flags_q[4];
		rec.field_width = width_wide[OUT_CNT_BITS-1:0];
		rec.prec_given = seen_q;
		rec.prec_value = seen_q ? prec_wide[OUT_CNT_BITS-1:0] : '0;
		rec.length_mod = len_q;
		rec.conversion = ch_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			flags_q <= '0;
			width_q <= '0;
			prec_q <= '0;
			seen_q <= 1'b0;
			len_q <= LEN_NONE;
		end else if (fire) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			width_q <= width_d;
			prec_q <= prec_d;
			seen_q <= seen_d;
			len_q <= len_d;
		end
	end

endmodule

@@ rtl/core/fsfp_out_reg.sv @@
// Result register of the format specification flag parser.
// Holds one finished record until the downstream side takes it; uses fsfp_pkg.
module fsfp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  fsfp_pkg::rec_t rec_in,
	input  logic           out_stall,
	output logic           out_valid,
	output logic           can_take,
	output fsfp_pkg::rec_t rec_q
);
	import fsfp_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;
	assign can_take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_in;
		end
	end

endmodule

@@ rtl/core/format_spec_flag_parser_top.sv @@
// A word ending a spec is registered at the input, and its result in the result register.
// Throughput: one word per cycle; a result held by out_stall stops the parse and input.
// Each word is handled in one pass of the parse logic between the input and result registers.
// Reset: arst_n clears the parse state to the flag phase and empties both registers.
// Top level of the format specification flag parser; uses fsfp_pkg,
// fsfp_in_stage, fsfp_parse_core and fsfp_out_reg.
module format_spec_flag_parser_top #(
	parameter int COUNT_BITS = fsfp_pkg::COUNT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [7:0]                             ch,
	input  logic signed [fsfp_pkg::STAR_BITS-1:0]  star_arg,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   left_justify,
	output logic                                   plus_sign,
	output logic                                   space_sign,
	output logic                                   zero_pad,
	output logic                                   alt_form,
	output logic [fsfp_pkg::OUT_CNT_BITS-1:0]      field_width,
	output logic                                   prec_given,
	output logic [fsfp_pkg::OUT_CNT_BITS-1:0]      prec_value,
	output logic [2:0]                             length_mod,
	output logic [7:0]                             conversion
);
	import fsfp_pkg::*;

	logic                  can_take;
	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  star_neg_s1;
	logic [COUNT_BITS-1:0] star_sat_s1;
	logic                  fire;
	logic                  emit;
	rec_t                  rec_d;
	rec_t                  rec_q;

	assign fire = valid_s1 && can_take;

	fsfp_in_stage #(.COUNT_BITS(COUNT_BITS)) u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.star_arg    (star_arg),
		.advance     (can_take),
		.valid_s1    (valid_s1),
		.ch_s1       (ch_s1),
		.star_neg_s1 (star_neg_s1),
		.star_sat_s1 (star_sat_s1)
	);

	fsfp_parse_core #(.COUNT_BITS(COUNT_BITS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.ch_s1       (ch_s1),
		.star_neg_s1 (star_neg_s1),
		.star_sat_s1 (star_sat_s1),
		.emit        (emit),
		.rec         (rec_d)
	);

	fsfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && emit),
		.rec_in    (rec_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.can_take  (can_take),
		.rec_q     (rec_q)
	);

	assign left_justify = rec_q.left_justify;
	assign plus_sign = rec_q.plus_sign;
	assign space_sign = rec_q.space_sign;
	assign zero_pad = rec_q.zero_pad;
	assign alt_form = rec_q.alt_form;
	assign field_width = rec_q.field_width;
	assign prec_given = rec_q.prec_given;
	assign prec_value = rec_q.prec_value;
	assign length_mod = rec_q.length_mod;
	assign conversion = rec_q.conversion;

endmodule

@@ rtl/core/fsfp_checker.sv @@
// Port checker for the format specification flag parser, bound to the top level.
// Sees only the top-level ports; uses fsfp_pkg.
module fsfp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [7:0]                        ch,
	input logic signed [fsfp_pkg::STAR_BITS-1:0] star_arg,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              left_justify,
	input logic                              plus_sign,
	input logic                              space_sign,
	input logic                              zero_pad,
	input logic                              alt_form,
	input logic [fsfp_pkg::OUT_CNT_BITS-1:0] field_width,
	input logic                              prec_given,
	input logic [fsfp_pkg::OUT_CNT_BITS-1:0] prec_value,
	input logic [2:0]                        length_mod,
	input logic [7:0]                        conversion
);
	import fsfp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(conversion) && $stable(field_width))
		else $error("Stalled result word changed.");

	a_plus_over_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(plus_sign && space_sign))
		else $error("Space sign reported together with plus sign.");

	a_left_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(left_justify && zero_pad))
		else $error("Zero padding reported together with left alignment.");

	a_prec_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !prec_given |-> prec_value == '0)
		else $error("Precision value set without a precision.");

	a_len_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length_mod <= LEN_BIG_L)
		else $error("Length modifier code out of range.");

endmodule

bind format_spec_flag_parser_top fsfp_checker u_fsfp_checker (.*);
